// ===== sv/dbpp_pkg.sv =====
package dbpp_pkg;

   // Field widths fixed by the interface.
   localparam int COUNT_W     = 10;
   localparam int TIME_W      = 10;
   localparam int ROAD_W      = 2;
   localparam int FIELD_COUNT = 4;

   // Product of a count and the cycle time, and the divider step counter.
   localparam int PROD_W    = COUNT_W + TIME_W;
   localparam int DIV_CNT_W = $clog2(PROD_W);

   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

   localparam int DEFAULT_ROAD_COUNT = 4;

   // Configuration port.
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [1:0] REG_ADAPTIVE_MODE = 2'd0;
   localparam logic [1:0] REG_CYCLE_SECONDS = 2'd1;
   localparam logic [1:0] REG_MIN_GREEN     = 2'd2;
   localparam logic [1:0] REG_FIXED_GREEN   = 2'd3;

   // Register reset values.
   localparam logic              ADAPTIVE_RESET    = 1'b1;
   localparam logic [TIME_W-1:0] CYCLE_RESET       = 10'd120;
   localparam logic [TIME_W-1:0] MIN_GREEN_RESET   = 10'd5;
   localparam logic [TIME_W-1:0] FIXED_GREEN_RESET = 10'd30;

endpackage

// ===== sv/density_based_signal_phase_picker_core.sv =====
// Channel   Direction  Handshake                        Payload
// req       in         req_valid / req_ready            four road counts, 10 bits each
// rsp       out        rsp_valid / rsp_ready            ended road and count, next road and time
// csr       in/out     csr_psel, csr_penable, csr_pwrite register write and read, 32-bit data
//
// One phase-end event is taken at a time. A fixed-mode event runs the road scan (one road a
// cycle) and then loads its result; an adaptive event runs the road scan, the multiply, the
// 20-step restoring divider and the saturation step before its result is loaded.
// A new event is taken while the previous result still waits on rsp; the next result waits
// for that transfer before it is loaded. Reset is synchronous and active high; it restores the
// registers, road 0 green and served, and a last green time of zero. No clearing pass is needed.
module density_based_signal_phase_picker_core #(
   parameter int ROAD_COUNT = dbpp_pkg::DEFAULT_ROAD_COUNT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // Phase-end events
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [dbpp_pkg::COUNT_W-1:0]         req_count_north,
   input  logic [dbpp_pkg::COUNT_W-1:0]         req_count_east,
   input  logic [dbpp_pkg::COUNT_W-1:0]         req_count_south,
   input  logic [dbpp_pkg::COUNT_W-1:0]         req_count_west,
   // Phase decisions
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [dbpp_pkg::ROAD_W-1:0]          rsp_ended_road,
   output logic [dbpp_pkg::COUNT_W-1:0]         rsp_ended_road_count,
   output logic [dbpp_pkg::ROAD_W-1:0]          rsp_next_green_road,
   output logic [dbpp_pkg::TIME_W-1:0]          rsp_green_seconds,
   // Register port
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [dbpp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [dbpp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [dbpp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import dbpp_pkg::*;

   localparam int IDX_W = $clog2(ROAD_COUNT);
   localparam int SUM_W = $clog2(ROAD_COUNT * ((1 << COUNT_W) - 1) + 2);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_MUL,
      ST_DIV,
      ST_SAT,
      ST_OUTPUT
   } state_type;

   // Registers.
   state_type            state_ff, state_in;
   logic                 adaptive_ff, adaptive_in;
   logic [TIME_W-1:0]    cycle_ff, cycle_in;
   logic [TIME_W-1:0]    min_green_ff, min_green_in;
   logic [TIME_W-1:0]    fixed_green_ff, fixed_green_in;
   logic [IDX_W-1:0]     current_green_ff, current_green_in;
   logic [ROAD_COUNT-1:0] served_ff, served_in;
   logic [TIME_W-1:0]    last_green_ff, last_green_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   logic [COUNT_W-1:0]   cnt_ff [ROAD_COUNT];
   logic [COUNT_W-1:0]   cnt_in [ROAD_COUNT];
   logic [IDX_W-1:0]     idx_ff, idx_in;
   logic [SUM_W-1:0]     sum_ff, sum_in;
   logic                 found_ff, found_in;
   logic [IDX_W-1:0]     pick_ff, pick_in;
   logic [COUNT_W-1:0]   best_ff, best_in;
   logic [PROD_W-1:0]    dvd_ff, dvd_in;
   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic [TIME_W-1:0]    time_ff, time_in;
   logic [IDX_W-1:0]     ended_ff, ended_in;
   logic [COUNT_W-1:0]   ended_count_ff, ended_count_in;

   logic [ROAD_W-1:0]    rsp_ended_ff, rsp_ended_in;
   logic [COUNT_W-1:0]   rsp_ended_count_ff, rsp_ended_count_in;
   logic [ROAD_W-1:0]    rsp_next_ff, rsp_next_in;
   logic [TIME_W-1:0]    rsp_time_ff, rsp_time_in;

   // Combinational helpers.
   logic [COUNT_W-1:0]   field_count [FIELD_COUNT];
   logic [COUNT_W-1:0]   raw_count [ROAD_COUNT];
   logic [COUNT_W-1:0]   ended_raw;
   logic [COUNT_W-1:0]   ended_reduced;
   logic                 req_fire;
   logic                 csr_write;
   logic [1:0]           csr_index;
   logic [COUNT_W-1:0]   scan_count;
   logic                 scan_take;
   logic [PROD_W-1:0]    product;
   logic [SUM_W:0]       div_trial;
   logic [SUM_W:0]       div_diff;
   logic                 div_bit;
   logic [IDX_W+ROAD_W-1:0] ended_wide;
   logic [IDX_W+ROAD_W-1:0] pick_wide;

   assign field_count[0] = req_count_north;
   assign field_count[1] = req_count_east;
   assign field_count[2] = req_count_south;
   assign field_count[3] = req_count_west;

   // Roads beyond the four detector fields always see an empty approach.
   for (genvar g = 0; g < ROAD_COUNT; g++) begin : g_raw
      if (g < FIELD_COUNT) begin : g_field
         assign raw_count[g] = field_count[g];
      end else begin : g_empty
         assign raw_count[g] = '0;
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_fire   = req_valid && req_ready;
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = csr_paddr[3:2];

   // The road whose green ended loses as many vehicles as it had seconds of green.
   assign ended_raw     = raw_count[current_green_ff];
   assign ended_reduced = (ended_raw > last_green_ff) ? (ended_raw - last_green_ff) : '0;

   // Scan step: the first unserved road is taken in either mode, and in adaptive mode a
   // strictly larger count replaces it, so ties go to the lower index.
   assign scan_count = cnt_ff[idx_ff];
   assign scan_take  = !served_ff[idx_ff] &&
                       (!found_ff || (adaptive_ff && (scan_count > best_ff)));

   assign product = best_ff * cycle_ff;

   // Restoring divider step; sum_ff already holds one plus the sum of counts.
   assign div_trial = {rem_ff, dvd_ff[PROD_W-1]};
   assign div_diff  = div_trial - {1'b0, sum_ff};
   assign div_bit   = !div_diff[SUM_W];

   assign ended_wide = {{ROAD_W{1'b0}}, ended_ff};
   assign pick_wide  = {{ROAD_W{1'b0}}, pick_ff};

   always_comb begin
      state_in           = state_ff;
      adaptive_in        = adaptive_ff;
      cycle_in           = cycle_ff;
      min_green_in       = min_green_ff;
      fixed_green_in     = fixed_green_ff;
      current_green_in   = current_green_ff;
      served_in          = served_ff;
      last_green_in      = last_green_ff;
      rsp_valid_in       = rsp_valid_ff;
      cnt_in             = cnt_ff;
      idx_in             = idx_ff;
      sum_in             = sum_ff;
      found_in           = found_ff;
      pick_in            = pick_ff;
      best_in            = best_ff;
      dvd_in             = dvd_ff;
      rem_in             = rem_ff;
      div_cnt_in         = div_cnt_ff;
      time_in            = time_ff;
      ended_in           = ended_ff;
      ended_count_in     = ended_count_ff;
      rsp_ended_in       = rsp_ended_ff;
      rsp_ended_count_in = rsp_ended_count_ff;
      rsp_next_in        = rsp_next_ff;
      rsp_time_in        = rsp_time_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (csr_write) begin
         case (csr_index)
            REG_ADAPTIVE_MODE: adaptive_in    = csr_pwdata[0];
            REG_CYCLE_SECONDS: cycle_in       = csr_pwdata[TIME_W-1:0];
            REG_MIN_GREEN:     min_green_in   = csr_pwdata[TIME_W-1:0];
            REG_FIXED_GREEN:   fixed_green_in = csr_pwdata[TIME_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               for (int i = 0; i < ROAD_COUNT; i++) begin
                  cnt_in[i] = (IDX_W'(i) == current_green_ff) ? ended_reduced : raw_count[i];
               end
               ended_in       = current_green_ff;
               ended_count_in = ended_reduced;
               if (&served_ff) begin
                  served_in = '0;
               end
               idx_in   = '0;
               sum_in   = SUM_W'(1);
               found_in = 1'b0;
               pick_in  = '0;
               best_in  = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            sum_in = sum_ff + SUM_W'(scan_count);
            if (scan_take) begin
               found_in = 1'b1;
               pick_in  = idx_ff;
               best_in  = scan_count;
            end
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IDX_W'(ROAD_COUNT - 1)) begin
               if (adaptive_ff) begin
                  state_in = ST_MUL;
               end else begin
                  time_in  = fixed_green_ff;
                  state_in = ST_OUTPUT;
               end
            end
         end
         ST_MUL: begin
            dvd_in     = product;
            rem_in     = '0;
            div_cnt_in = '0;
            state_in   = ST_DIV;
         end
         ST_DIV: begin
            rem_in     = div_bit ? div_diff[SUM_W-1:0] : div_trial[SUM_W-1:0];
            dvd_in     = {dvd_ff[PROD_W-2:0], div_bit};
            div_cnt_in = div_cnt_ff + 1'b1;
            if (div_cnt_ff == DIV_CNT_W'(PROD_W - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (dvd_ff < PROD_W'(min_green_ff)) begin
               time_in = min_green_ff;
            end else if (dvd_ff > PROD_W'(TIME_MAX)) begin
               time_in = TIME_MAX;
            end else begin
               time_in = dvd_ff[TIME_W-1:0];
            end
            state_in = ST_OUTPUT;
         end
         ST_OUTPUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in       = 1'b1;
               rsp_ended_in       = ended_wide[ROAD_W-1:0];
               rsp_ended_count_in = ended_count_ff;
               rsp_next_in        = pick_wide[ROAD_W-1:0];
               rsp_time_in        = time_ff;
               current_green_in   = pick_ff;
               served_in          = served_ff | (ROAD_COUNT'(1) << pick_ff);
               last_green_in      = time_ff;
               state_in           = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         adaptive_ff      <= ADAPTIVE_RESET;
         cycle_ff         <= CYCLE_RESET;
         min_green_ff     <= MIN_GREEN_RESET;
         fixed_green_ff   <= FIXED_GREEN_RESET;
         current_green_ff <= '0;
         served_ff        <= ROAD_COUNT'(1);
         last_green_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         adaptive_ff      <= adaptive_in;
         cycle_ff         <= cycle_in;
         min_green_ff     <= min_green_in;
         fixed_green_ff   <= fixed_green_in;
         current_green_ff <= current_green_in;
         served_ff        <= served_in;
         last_green_ff    <= last_green_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
      cnt_ff             <= cnt_in;
      idx_ff             <= idx_in;
      sum_ff             <= sum_in;
      found_ff           <= found_in;
      pick_ff            <= pick_in;
      best_ff            <= best_in;
      dvd_ff             <= dvd_in;
      rem_ff             <= rem_in;
      div_cnt_ff         <= div_cnt_in;
      time_ff            <= time_in;
      ended_ff           <= ended_in;
      ended_count_ff     <= ended_count_in;
      rsp_ended_ff       <= rsp_ended_in;
      rsp_ended_count_ff <= rsp_ended_count_in;
      rsp_next_ff        <= rsp_next_in;
      rsp_time_ff        <= rsp_time_in;
   end

   // Register read-back, zero-extended to the bus.
   always_comb begin
      case (csr_index)
         REG_ADAPTIVE_MODE: csr_prdata = CSR_DATA_W'(adaptive_ff);
         REG_CYCLE_SECONDS: csr_prdata = CSR_DATA_W'(cycle_ff);
         REG_MIN_GREEN:     csr_prdata = CSR_DATA_W'(min_green_ff);
         REG_FIXED_GREEN:   csr_prdata = CSR_DATA_W'(fixed_green_ff);
         default:           csr_prdata = '0;
      endcase
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_ended_road       = rsp_ended_ff;
   assign rsp_ended_road_count = rsp_ended_count_ff;
   assign rsp_next_green_road  = rsp_next_ff;
   assign rsp_green_seconds    = rsp_time_ff;

endmodule

// ===== tb/sv/tb_density_based_signal_phase_picker_core.sv =====
`timescale 1ns / 1ps

// Testbench for the density-based signal phase picker.
//
// Every phase-end event that the block takes is run through a predictor kept here, which holds
// its own copy of the green road, the served marks, the last green time and the four registers.
// The predicted decision is queued at the transfer on req, and each transfer on rsp is compared
// field by field with the oldest queued decision.
//
// The run opens with a directed table: the all-zero and all-maximum count sets, alternating
// bit patterns, ties, the register extremes, a zero cycle time, fixed mode and a change of
// mode between events. Six random phases follow, each under its own register setting. The
// registers are only written once every outstanding decision has come back, and each write is
// read back over the register port.
module tb_density_based_signal_phase_picker_core;
   import dbpp_pkg::*;

   localparam int ROADS          = DEFAULT_ROAD_COUNT;
   localparam int RANDOM_PHASES  = 6;
   localparam int PHASE_EVENTS   = 72;
   // Settling wait at the end of the run; it leaves ample margin for a late adaptive result.
   localparam int SETTLE_CYCLES  = 40;
   // Quiet cycles allowed before the run is declared stuck. The slowest event sees the sender
   // gap, the divider and the longest receiver stall.
   localparam int WATCHDOG_LIMIT = 2000;

   typedef logic [FIELD_COUNT-1:0][COUNT_W-1:0] road_counts_t;

   typedef struct packed {
      logic [ROAD_W-1:0]  ended_road;
      logic [COUNT_W-1:0] ended_count;
      logic [ROAD_W-1:0]  next_road;
      logic [TIME_W-1:0]  green_secs;
   } phase_decision_t;

   typedef enum logic {STEP_EVENT, STEP_WRITE} script_kind_e;

   typedef struct {
      script_kind_e       kind;
      road_counts_t       counts;
      bit                 typed;
      phase_decision_t    want;
      logic [1:0]         reg_idx;
      logic [TIME_W-1:0]  value;
   } script_row_t;

   // Clock, reset and the block's inputs, all known from time zero.
   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid       = 1'b0;
   logic                  req_ready;
   logic [COUNT_W-1:0]    req_count_north = '0;
   logic [COUNT_W-1:0]    req_count_east  = '0;
   logic [COUNT_W-1:0]    req_count_south = '0;
   logic [COUNT_W-1:0]    req_count_west  = '0;

   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [ROAD_W-1:0]     rsp_ended_road;
   logic [COUNT_W-1:0]    rsp_ended_road_count;
   logic [ROAD_W-1:0]     rsp_next_green_road;
   logic [TIME_W-1:0]     rsp_green_seconds;

   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: the signal as the block should see it, and its register copies.
   logic [ROAD_W-1:0]     sig_green     = '0;
   logic [ROADS-1:0]      served_set    = ROADS'(1);
   logic [TIME_W-1:0]     last_grant    = '0;
   logic                  cfg_adaptive  = ADAPTIVE_RESET;
   logic [TIME_W-1:0]     cfg_cycle     = CYCLE_RESET;
   logic [TIME_W-1:0]     cfg_min_green = MIN_GREEN_RESET;
   logic [TIME_W-1:0]     cfg_fixed     = FIXED_GREEN_RESET;

   // Decisions predicted at the req transfer and not yet seen on rsp.
   phase_decision_t       decision_q[$];
   script_row_t           script[$];

   // Sender pacing: bursts of transfers separated by random gaps, unless the flow is steady.
   int                    burst_left  = 0;
   bit                    steady_flow = 1'b0;

   // Receiver stall pattern, reloaded whenever the slot counter wraps.
   logic [15:0]           stall_pattern = '1;
   logic [3:0]            stall_slot    = '0;

   int                    mismatches        = 0;
   int                    events_sent       = 0;
   int                    decisions_checked = 0;
   int                    writes_done       = 0;
   int                    floor_hits        = 0;
   int                    drain_pauses      = 0;
   int                    quiet_cycles      = 0;

   always #4 clock = ~clock;

   density_based_signal_phase_picker_core DUT (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_count_north      (req_count_north),
      .req_count_east       (req_count_east),
      .req_count_south      (req_count_south),
      .req_count_west       (req_count_west),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ended_road       (rsp_ended_road),
      .rsp_ended_road_count (rsp_ended_road_count),
      .rsp_next_green_road  (rsp_next_green_road),
      .rsp_green_seconds    (rsp_green_seconds),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   task automatic report_mismatch(input string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
   endtask

   // Works out the decision for one phase-end event and moves the predicted signal state on.
   // The green road that has just ended first has its count cut by the time it was granted,
   // never going below zero. Once every road has been served the marks start afresh.
   function automatic phase_decision_t pick_next_phase(input road_counts_t counts);
      int unsigned     cnt [ROADS];
      int unsigned     total;
      int unsigned     grant;
      int unsigned     ended;
      int unsigned     pick;
      bit              found;
      phase_decision_t d;
      total = 0;
      pick  = 0;
      found = 1'b0;
      ended = sig_green % ROADS;
      for (int i = 0; i < ROADS; i++) begin
         cnt[i] = counts[i];
      end
      if (cnt[ended] > last_grant) begin
         cnt[ended] = cnt[ended] - last_grant;
      end else begin
         if (cnt[ended] < last_grant) floor_hits++;
         cnt[ended] = 0;
      end
      if (&served_set) served_set = '0;
      if (cfg_adaptive) begin
         // The busiest unserved road wins; a tie stays with the lower index.
         for (int i = 0; i < ROADS; i++) begin
            total += cnt[i];
            if (!served_set[i] && (!found || cnt[i] > cnt[pick])) begin
               pick  = i;
               found = 1'b1;
            end
         end
         grant = (cnt[pick] * cfg_cycle) / (1 + total);
         if (grant < cfg_min_green) grant = cfg_min_green;
         if (grant > TIME_MAX) grant = TIME_MAX;
      end else begin
         // Round robin: the lowest unserved road, scanned from the top down.
         for (int i = ROADS - 1; i >= 0; i--) begin
            if (!served_set[i]) pick = i;
         end
         grant = cfg_fixed;
      end
      served_set[pick] = 1'b1;
      sig_green        = ROAD_W'(pick);
      last_grant       = TIME_W'(grant);
      d.ended_road     = ROAD_W'(ended);
      d.ended_count    = COUNT_W'(cnt[ended]);
      d.next_road      = ROAD_W'(pick);
      d.green_secs     = TIME_W'(grant);
      return d;
   endfunction

   // Offers one event on req and holds it until the transfer. A typed row supplies its own
   // decision, but the predictor still runs so that its state stays in step with the block.
   task automatic send_event(input road_counts_t counts, input bit typed,
                             input phase_decision_t want);
      phase_decision_t predicted;
      int              gap;
      req_valid       <= 1'b1;
      req_count_north <= counts[0];
      req_count_east  <= counts[1];
      req_count_south <= counts[2];
      req_count_west  <= counts[3];
      do @(posedge clock); while (!req_ready);
      predicted = pick_next_phase(counts);
      decision_q.push_back(typed ? want : predicted);
      events_sent++;
      gap = 0;
      if (!steady_flow) begin
         if (burst_left == 0) begin
            gap        = $urandom_range(1, 8);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Lowers valid and holds off the sender until every predicted decision has been seen.
   task automatic wait_idle();
      req_valid <= 1'b0;
      drain_pauses++;
      do @(posedge clock); while (decision_q.size() != 0);
   endtask

   // One register write over the setup and access cycles, then a read of the same register.
   task automatic write_register(input logic [1:0] idx, input logic [TIME_W-1:0] value);
      logic [CSR_DATA_W-1:0] readback;
      logic [CSR_DATA_W-1:0] stored;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         REG_ADAPTIVE_MODE: cfg_adaptive  = value[0];
         REG_CYCLE_SECONDS: cfg_cycle     = value;
         REG_MIN_GREEN:     cfg_min_green = value;
         REG_FIXED_GREEN:   cfg_fixed     = value;
         default: ;
      endcase
      stored = (idx == REG_ADAPTIVE_MODE) ? CSR_DATA_W'(value[0]) : CSR_DATA_W'(value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      readback     = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (readback !== stored)
         report_mismatch($sformatf("register %0d reads back %0h, written %0h",
                                   idx, readback, stored));
      writes_done++;
   endtask

   function automatic void row_event(input int n, input int e, input int s, input int w);
      script_row_t r;
      r.kind      = STEP_EVENT;
      r.counts[0] = COUNT_W'(n);
      r.counts[1] = COUNT_W'(e);
      r.counts[2] = COUNT_W'(s);
      r.counts[3] = COUNT_W'(w);
      r.typed     = 1'b0;
      r.want      = '0;
      r.reg_idx   = '0;
      r.value     = '0;
      script.push_back(r);
   endfunction

   function automatic void row_typed(input int n, input int e, input int s, input int w,
                                     input int er, input int ec, input int nr, input int gs);
      row_event(n, e, s, w);
      script[$].typed            = 1'b1;
      script[$].want.ended_road  = ROAD_W'(er);
      script[$].want.ended_count = COUNT_W'(ec);
      script[$].want.next_road   = ROAD_W'(nr);
      script[$].want.green_secs  = TIME_W'(gs);
   endfunction

   function automatic void row_write(input logic [1:0] idx, input int value);
      script_row_t r;
      r.kind    = STEP_WRITE;
      r.counts  = '0;
      r.typed   = 1'b0;
      r.want    = '0;
      r.reg_idx = idx;
      r.value   = TIME_W'(value);
      script.push_back(r);
   endfunction

   // Result side. Each transfer on rsp is checked against the oldest predicted decision; the
   // ready line then follows a pattern, reloaded on each wrap of the slot counter, which is
   // either solid, random, mostly stalled or mostly open.
   always @(posedge clock) begin
      phase_decision_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decision_q.size() == 0) begin
            report_mismatch($sformatf("decision for road %0d arrived with none outstanding",
                                      rsp_next_green_road));
         end else begin
            want = decision_q.pop_front();
            if (rsp_ended_road !== want.ended_road)
               report_mismatch($sformatf("ended road %0d, expected %0d",
                                         rsp_ended_road, want.ended_road));
            if (rsp_ended_road_count !== want.ended_count)
               report_mismatch($sformatf("ended road count %0d, expected %0d",
                                         rsp_ended_road_count, want.ended_count));
            if (rsp_next_green_road !== want.next_road)
               report_mismatch($sformatf("next green road %0d, expected %0d",
                                         rsp_next_green_road, want.next_road));
            if (rsp_green_seconds !== want.green_secs)
               report_mismatch($sformatf("green seconds %0d, expected %0d",
                                         rsp_green_seconds, want.green_secs));
            decisions_checked++;
         end
      end
      if (stall_slot == 0) begin
         case ($urandom_range(0, 3))
            0:       stall_pattern = '1;
            1:       stall_pattern = 16'($urandom);
            2:       stall_pattern = 16'($urandom & $urandom);
            default: stall_pattern = 16'($urandom | $urandom);
         endcase
      end
      rsp_ready  <= stall_pattern[stall_slot];
      stall_slot  = stall_slot + 1'b1;
   end

   // Watchdog: any transfer or register access counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no transfer for %0d cycles", $time, quiet_cycles);
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      road_counts_t counts;
      int           directed_events;
      int           v;
      logic         mode_sel;
      int           cyc;
      int           min_g;

      // The directed table. The first four decisions follow straight from the reset state:
      // road 0 is green and served with no time granted, so an empty junction hands green
      // to roads 1 and 2 at the minimum time; full counts then leave road 3 as the only
      // unserved road, after which every mark is cleared and the tie goes to road 0.
      row_typed(0, 0, 0, 0,              0, 0,    1, 5);
      row_typed(0, 0, 0, 0,              1, 0,    2, 5);
      row_typed(1023, 1023, 1023, 1023,  2, 1018, 3, 30);
      row_typed(1023, 1023, 1023, 1023,  3, 993,  0, 30);
      row_event(10'h2AA, 10'h155, 10'h2AA, 10'h155);
      row_event(10'h155, 10'h2AA, 10'h155, 10'h2AA);
      row_event(7, 7, 7, 7);
      // Longest cycle with one busy road, then a zero cycle which leaves only the minimum.
      row_write(REG_CYCLE_SECONDS, 1023);
      row_event(1023, 0, 0, 0);
      row_event(0, 1023, 0, 0);
      row_write(REG_CYCLE_SECONDS, 0);
      row_event(500, 400, 300, 200);
      // The highest minimum overrides any share; a zero minimum with the cycle register at 1
      // lets the computed time fall to nothing.
      row_write(REG_MIN_GREEN, 1023);
      row_event(900, 17, 1023, 3);
      row_write(REG_MIN_GREEN, 0);
      row_write(REG_CYCLE_SECONDS, 1);
      row_event(10, 20, 30, 40);
      // Fixed round robin at both extremes of the fixed time.
      row_write(REG_ADAPTIVE_MODE, 0);
      row_write(REG_FIXED_GREEN, 0);
      row_event(1, 2, 3, 4);
      row_event(1023, 1023, 1023, 1023);
      row_event(0, 0, 0, 0);
      row_write(REG_FIXED_GREEN, 1023);
      row_event(1023, 0, 1023, 0);
      row_event(5, 1000, 5, 1000);
      row_event(1023, 1023, 1023, 1023);
      // Back to adaptive with the served marks and the last grant carried across the change.
      row_write(REG_ADAPTIVE_MODE, 1);
      row_write(REG_CYCLE_SECONDS, 120);
      row_write(REG_MIN_GREEN, 5);
      row_event(1023, 0, 0, 0);
      row_event(40, 300, 600, 12);
      row_write(REG_FIXED_GREEN, 30);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (script[k]) begin
         if (script[k].kind == STEP_WRITE) begin
            wait_idle();
            write_register(script[k].reg_idx, script[k].value);
         end else begin
            send_event(script[k].counts, script[k].typed, script[k].want);
         end
      end
      directed_events = events_sent;

      // Random phases. Each begins with the block idle and a fresh setting of every
      // register, the extremes among them; two of the phases run in fixed mode and two
      // send with no gaps at all.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         wait_idle();
         mode_sel = (ph == 1 || ph == 4) ? 1'b0 : 1'b1;
         case ($urandom_range(0, 3))
            0:       cyc = 1;
            1:       cyc = 1023;
            default: cyc = $urandom_range(1, 1023);
         endcase
         case ($urandom_range(0, 5))
            0:       min_g = 0;
            1:       min_g = 1023;
            2:       min_g = $urandom_range(0, 1023);
            default: min_g = $urandom_range(0, 40);
         endcase
         write_register(REG_ADAPTIVE_MODE, TIME_W'(mode_sel));
         write_register(REG_CYCLE_SECONDS, TIME_W'(cyc));
         write_register(REG_MIN_GREEN, TIME_W'(min_g));
         write_register(REG_FIXED_GREEN, TIME_W'($urandom_range(0, 1023)));
         steady_flow = (ph == 2 || ph == 5);
         for (int n = 0; n < PHASE_EVENTS; n++) begin
            // Counts mix empty and full roads, light traffic and the whole range.
            for (int i = 0; i < FIELD_COUNT; i++) begin
               case ($urandom_range(0, 9))
                  0:       v = 0;
                  1:       v = 1023;
                  2, 3:    v = $urandom_range(0, 15);
                  default: v = $urandom_range(0, 1023);
               endcase
               counts[i] = COUNT_W'(v);
            end
            // Now and then the road just ended carries about its granted time, so that the
            // reduction lands on or around the floor at zero.
            if ($urandom_range(0, 3) == 0) begin
               v = int'(last_grant) + int'($urandom_range(0, 4)) - 2;
               if (v < 0) v = 0;
               if (v > 1023) v = 1023;
               counts[sig_green] = COUNT_W'(v);
            end
            send_event(counts, 1'b0, '0);
            if ($urandom_range(0, 59) == 0) wait_idle();
         end
      end

      wait_idle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (decision_q.size() != 0)
         report_mismatch($sformatf("%0d decisions never arrived", decision_q.size()));

      $display("Sent %0d phase-end events (%0d from the directed table) and checked %0d decisions.",
               events_sent, directed_events, decisions_checked);
      $display("Register writes read back: %0d; counts held at zero: %0d; drain pauses: %0d.",
               writes_done, floor_hits, drain_pauses);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
